>>> rtl/mtt_pkg.sv
// shared types, constants and helpers of the text tokenizer
`timescale 1ns / 1ps
`default_nettype none

package mtt_pkg;

    localparam int LINE_BITS = 24;
    localparam int OUT_LINE_W = 24;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_EOI  = 2'd2,
        KIND_EOQ  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        logic       quoted;
        logic       comment;
    } res_t;

    // all results caused by one byte; the line number is common to them
    typedef struct packed {
        logic [1:0]            count;
        res_t [2:0]            res;
        logic [OUT_LINE_W-1:0] line;
    } run_t;

    function automatic logic [OUT_LINE_W-1:0] line_out(input logic [LINE_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[OUT_LINE_W-1:0];
    endfunction

    function automatic res_t mk_res(input kind_t k, input logic [7:0] ch,
                                    input logic q, input logic c);
        res_t r;
        r.kind    = k;
        r.ch      = (k == KIND_CHAR) ? ch : CH_NUL;
        r.quoted  = q;
        r.comment = c;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/mtt_in_if.sv
// input channel carrying one text byte per transfer
`timescale 1ns / 1ps
`default_nettype none

interface mtt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/mtt_out_if.sv
// output channel carrying one tokenizer result per transfer
`timescale 1ns / 1ps
`default_nettype none

interface mtt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  token_char;
    logic        in_quotes;
    logic        is_comment;
    logic [23:0] line_count;
    logic        last_of_run;

    modport source (output valid, output kind, output token_char, output in_quotes,
                    output is_comment, output line_count, output last_of_run,
                    input ready);
    modport sink (input valid, input kind, input token_char, input in_quotes,
                  input is_comment, input line_count, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/mtt_front.sv
// front end: byte scanner that turns each byte into a run of results
`timescale 1ns / 1ps
`default_nettype none

module mtt_front
    import mtt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mtt_in_if.sink     in_ch,
    input  wire logic  cfg_we,
    input  wire logic  cfg_wdata,
    input  wire logic  q_full,
    output logic       q_push,
    output run_t       q_data
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'd0,
        S_SLASH  = 4'd1,
        S_BARE   = 4'd2,
        S_QUOTED = 4'd3,
        S_ESC    = 4'd4,
        S_ESCQ   = 4'd5,
        S_CSKIP  = 4'd6,
        S_CEMIT  = 4'd7
    } mode_t;

    mode_t                mode_reg, mode_next;
    logic                 quoted_reg, quoted_next;
    logic                 comment_reg, comment_next;
    logic                 emit_reg;
    logic [LINE_BITS-1:0] line_reg;
    logic                 line_inc;
    logic [1:0]           n;
    res_t [2:0]           slot;
    logic                 do_idle, do_bare, do_quoted;
    logic                 accept;
    logic [7:0]           b;

    assign b      = in_ch.text_byte;
    assign in_ch.ready = !q_full;
    assign accept = in_ch.valid && !q_full;

    always_comb
    begin
        mode_next    = mode_reg;
        quoted_next  = quoted_reg;
        comment_next = comment_reg;
        line_inc     = 1'b0;
        n            = 2'd0;
        slot         = '0;
        do_idle      = 1'b0;
        do_bare      = 1'b0;
        do_quoted    = 1'b0;

        case (mode_reg)
            S_SLASH:
            begin
                if (b == CH_SLASH)
                begin
                    if (emit_reg)
                    begin
                        comment_next = 1'b1;
                        mode_next    = S_CEMIT;
                        slot[0]      = mk_res(KIND_CHAR, CH_SLASH, quoted_next, 1'b1);
                        slot[1]      = mk_res(KIND_CHAR, CH_SLASH, quoted_next, 1'b1);
                        n            = 2'd2;
                    end
                    else
                    begin
                        mode_next = S_CSKIP;
                    end
                end
                else
                begin
                    mode_next = S_BARE;
                    slot[0]   = mk_res(KIND_CHAR, CH_SLASH, quoted_next, comment_next);
                    n         = 2'd1;
                    do_bare   = 1'b1;
                end
            end
            S_BARE:
            begin
                do_bare = 1'b1;
            end
            S_QUOTED:
            begin
                do_quoted = 1'b1;
            end
            S_ESC:
            begin
                if (b == CH_QUOTE)
                begin
                    mode_next = S_ESCQ;
                end
                else if (b == CH_NUL)
                begin
                    slot[0]   = mk_res(KIND_CHAR, CH_BSLASH, quoted_next, comment_next);
                    n         = 2'd1;
                    do_quoted = 1'b1;
                end
                else
                begin
                    slot[0]   = mk_res(KIND_CHAR, CH_BSLASH, quoted_next, comment_next);
                    slot[1]   = mk_res(KIND_CHAR, b, quoted_next, comment_next);
                    n         = 2'd2;
                    mode_next = S_QUOTED;
                end
            end
            S_ESCQ:
            begin
                slot[0] = mk_res(KIND_CHAR, CH_BSLASH, quoted_next, comment_next);
                if (b == CH_CR || b == CH_LF)
                begin
                    slot[1]      = mk_res(KIND_END, b, quoted_next, comment_next);
                    n            = 2'd2;
                    quoted_next  = 1'b0;
                    comment_next = 1'b0;
                    mode_next    = S_IDLE;
                    do_idle      = 1'b1;
                end
                else
                begin
                    slot[1]   = mk_res(KIND_CHAR, CH_QUOTE, quoted_next, comment_next);
                    n         = 2'd2;
                    mode_next = S_QUOTED;
                    do_quoted = 1'b1;
                end
            end
            S_CSKIP:
            begin
                if (b == CH_LF)
                begin
                    line_inc  = 1'b1;
                    mode_next = S_IDLE;
                end
                else if (b == CH_NUL)
                begin
                    slot[0]   = mk_res(KIND_EOI, b, quoted_next, comment_next);
                    n         = 2'd1;
                    mode_next = S_IDLE;
                end
            end
            S_CEMIT:
            begin
                if (b == CH_LF || b == CH_NUL)
                begin
                    slot[0]      = mk_res(KIND_END, b, quoted_next, comment_next);
                    n            = 2'd1;
                    quoted_next  = 1'b0;
                    comment_next = 1'b0;
                    mode_next    = S_IDLE;
                    if (b == CH_LF)
                    begin
                        line_inc = 1'b1;
                    end
                    else
                    begin
                        slot[1] = mk_res(KIND_EOI, b, 1'b0, 1'b0);
                        n       = 2'd2;
                    end
                end
                else
                begin
                    slot[0] = mk_res(KIND_CHAR, b, quoted_next, comment_next);
                    n       = 2'd1;
                end
            end
            default:
            begin
                mode_next = S_IDLE;
                do_idle   = 1'b1;
            end
        endcase

        if (do_bare)
        begin
            if (b > CH_SPACE)
            begin
                slot[n] = mk_res(KIND_CHAR, b, quoted_next, comment_next);
                n       = n + 2'd1;
            end
            else
            begin
                slot[n]      = mk_res(KIND_END, b, quoted_next, comment_next);
                n            = n + 2'd1;
                quoted_next  = 1'b0;
                comment_next = 1'b0;
                mode_next    = S_IDLE;
                if (b == CH_NUL)
                begin
                    slot[n] = mk_res(KIND_EOI, b, 1'b0, 1'b0);
                    n       = n + 2'd1;
                end
                else if (b == CH_LF)
                begin
                    line_inc = 1'b1;
                end
            end
        end

        if (do_quoted)
        begin
            if (b == CH_NUL)
            begin
                slot[n]     = mk_res(KIND_EOQ, b, quoted_next, comment_next);
                n           = n + 2'd1;
                quoted_next = 1'b0;
                mode_next   = S_IDLE;
            end
            else if (b == CH_QUOTE)
            begin
                slot[n]      = mk_res(KIND_END, b, quoted_next, comment_next);
                n            = n + 2'd1;
                quoted_next  = 1'b0;
                comment_next = 1'b0;
                mode_next    = S_IDLE;
            end
            else if (b == CH_BSLASH)
            begin
                mode_next = S_ESC;
            end
            else
            begin
                slot[n] = mk_res(KIND_CHAR, b, quoted_next, comment_next);
                n       = n + 2'd1;
            end
        end

        if (do_idle)
        begin
            if (b == CH_NUL)
            begin
                slot[n] = mk_res(KIND_EOI, b, quoted_next, comment_next);
                n       = n + 2'd1;
            end
            else if (b <= CH_SPACE)
            begin
                line_inc = (b == CH_LF);
            end
            else if (b == CH_SEMI)
            begin
                if (emit_reg)
                begin
                    comment_next = 1'b1;
                    mode_next    = S_CEMIT;
                    slot[n]      = mk_res(KIND_CHAR, b, quoted_next, 1'b1);
                    n            = n + 2'd1;
                end
                else
                begin
                    mode_next = S_CSKIP;
                end
            end
            else if (b == CH_SLASH)
            begin
                mode_next = S_SLASH;
            end
            else if (b == CH_QUOTE)
            begin
                quoted_next = 1'b1;
                mode_next   = S_QUOTED;
            end
            else
            begin
                mode_next = S_BARE;
                slot[n]   = mk_res(KIND_CHAR, b, quoted_next, comment_next);
                n         = n + 2'd1;
            end
        end
    end

    assign q_push       = accept && (n != 2'd0);
    assign q_data.count = n;
    assign q_data.res   = slot;
    assign q_data.line  = line_out(line_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= S_IDLE;
            quoted_reg  <= 1'b0;
            comment_reg <= 1'b0;
            line_reg    <= LINE_BITS'(1);
            emit_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                emit_reg <= cfg_wdata;
            end
            if (accept)
            begin
                mode_reg    <= mode_next;
                quoted_reg  <= quoted_next;
                comment_reg <= comment_next;
                if (line_inc && line_reg != '1)
                begin
                    line_reg <= line_reg + LINE_BITS'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/mtt_fifo.sv
// short queue of result runs between the scanner and the result sender
`timescale 1ns / 1ps
`default_nettype none

module mtt_fifo
    import mtt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  run_t       wdata,
    output logic       full,
    input  wire logic  pop,
    output run_t       rdata,
    output logic       not_empty
);

    run_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full      = (cnt_reg == QCNT_W'(QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign rdata     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == QPTR_W'(cnt_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

>>> rtl/mtt_back.sv
// back end: sends the results of each queued run one transfer at a time
`timescale 1ns / 1ps
`default_nettype none

module mtt_back
    import mtt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_valid,
    input  run_t       q_data,
    output logic       q_pop,
    mtt_out_if.source  out_ch
);

    logic                  valid_reg;
    logic [1:0]            idx_reg;
    kind_t                 kind_reg;
    logic [7:0]            char_reg;
    logic                  quoted_reg;
    logic                  comment_reg;
    logic [OUT_LINE_W-1:0] line_reg;
    logic                  last_reg;
    logic                  load;
    logic                  last;
    res_t                  cur;

    assign load  = q_valid && (!valid_reg || out_ch.ready);
    assign cur   = q_data.res[idx_reg];
    assign last  = (idx_reg == q_data.count - 2'd1);
    assign q_pop = load && last;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg    <= cur.kind;
            char_reg    <= cur.ch;
            quoted_reg  <= cur.quoted;
            comment_reg <= cur.comment;
            line_reg    <= q_data.line;
            last_reg    <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (out_ch.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid       = valid_reg;
    assign out_ch.kind        = kind_reg;
    assign out_ch.token_char  = char_reg;
    assign out_ch.in_quotes   = quoted_reg;
    assign out_ch.is_comment  = comment_reg;
    assign out_ch.line_count  = line_reg;
    assign out_ch.last_of_run = last_reg;

`ifndef NO_ASSERTIONS
    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> (idx_reg < q_data.count))
        else $error("result index beyond run length");
    a_idx_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> (idx_reg == 2'd0))
        else $error("result index left over with empty queue");
    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> (q_data.count != 2'd0))
        else $error("empty run in queue");
`endif

endmodule

`default_nettype wire

>>> rtl/map_text_tokenizer.sv
// top level of the streaming text tokenizer
`timescale 1ns / 1ps
`default_nettype none

// Streaming tokenizer: one text byte is taken per transfer on in_ch, and each
// byte yields zero to three results on out_ch (token characters, token ends,
// end of input, end of input inside quotes), the last one flagged with
// last_of_run. The scanner takes a byte every cycle while its four-entry run
// queue has room; the result sender sends one result per cycle while out_ch is
// ready. Bytes with no result (separators, skipped comments) are not queued.
// A byte's first result passes the run queue and the sender's output register.
// emit_comments is written through cfg_we/cfg_wdata and is sampled when a
// comment starts; the line counter resets to 1.
module map_text_tokenizer
    import mtt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mtt_in_if.sink     in_ch,
    mtt_out_if.source  out_ch,
    input  wire logic  cfg_we,
    input  wire logic  cfg_wdata
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    run_t q_wdata;
    run_t q_rdata;

    mtt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    mtt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_valid)
    );

    mtt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// self-checking testbench of the streaming text tokenizer
`timescale 1ns / 1ps

module tb
    import mtt_pkg::*;
();

    typedef enum logic [3:0] {
        SC_IDLE,
        SC_SLASH,
        SC_BARE,
        SC_QUOTED,
        SC_ESC,
        SC_ESCQ,
        SC_CSKIP,
        SC_CEMIT
    } scan_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  ch;
        logic        quoted;
        logic        comment;
        logic [23:0] line;
        logic        last;
    } token_res_t;

    class token_scoreboard;
        scan_t                mode;
        logic [LINE_BITS-1:0] line_cnt;
        logic                 quoted;
        logic                 comment;
        logic                 emit_on;
        token_res_t           run[$];
        token_res_t           due[$];
        int                   failures;

        function new();
            mode     = SC_IDLE;
            line_cnt = LINE_BITS'(1);
            quoted   = 1'b0;
            comment  = 1'b0;
            emit_on  = 1'b0;
            failures = 0;
        endfunction

        function void add(kind_t k, logic [7:0] ch);
            token_res_t r;
            r.kind    = k;
            r.ch      = (k == KIND_CHAR) ? ch : CH_NUL;
            r.quoted  = quoted;
            r.comment = comment;
            r.line    = 24'(line_cnt);
            r.last    = 1'b0;
            run.insert(run.size(), r);
        endfunction

        function void next_line();
            if (line_cnt != '1)
                line_cnt++;
        endfunction

        function void close_token();
            add(KIND_END, CH_NUL);
            quoted  = 1'b0;
            comment = 1'b0;
            mode    = SC_IDLE;
        endfunction

        function void idle_byte(logic [7:0] b);
            if (b == CH_NUL)
            begin
                add(KIND_EOI, CH_NUL);
            end
            else if (b <= CH_SPACE)
            begin
                if (b == CH_LF)
                    next_line();
            end
            else if (b == CH_SEMI)
            begin
                if (emit_on)
                begin
                    comment = 1'b1;
                    mode    = SC_CEMIT;
                    add(KIND_CHAR, b);
                end
                else
                begin
                    mode = SC_CSKIP;
                end
            end
            else if (b == CH_SLASH)
            begin
                mode = SC_SLASH;
            end
            else if (b == CH_QUOTE)
            begin
                quoted = 1'b1;
                mode   = SC_QUOTED;
            end
            else
            begin
                mode = SC_BARE;
                add(KIND_CHAR, b);
            end
        endfunction

        function void bare_byte(logic [7:0] b);
            if (b > CH_SPACE)
            begin
                add(KIND_CHAR, b);
            end
            else if (b == CH_NUL)
            begin
                close_token();
                add(KIND_EOI, CH_NUL);
            end
            else
            begin
                close_token();
                if (b == CH_LF)
                    next_line();
            end
        endfunction

        function void quoted_byte(logic [7:0] b);
            if (b == CH_NUL)
            begin
                add(KIND_EOQ, CH_NUL);
                quoted = 1'b0;
                mode   = SC_IDLE;
            end
            else if (b == CH_QUOTE)
            begin
                close_token();
            end
            else if (b == CH_BSLASH)
            begin
                mode = SC_ESC;
            end
            else
            begin
                add(KIND_CHAR, b);
            end
        endfunction

        // works out the results one accepted byte causes
        function void scan_byte(logic [7:0] b);
            run.delete();
            case (mode)
                SC_SLASH:
                begin
                    if (b == CH_SLASH)
                    begin
                        if (emit_on)
                        begin
                            comment = 1'b1;
                            mode    = SC_CEMIT;
                            add(KIND_CHAR, CH_SLASH);
                            add(KIND_CHAR, CH_SLASH);
                        end
                        else
                        begin
                            mode = SC_CSKIP;
                        end
                    end
                    else
                    begin
                        mode = SC_BARE;
                        add(KIND_CHAR, CH_SLASH);
                        bare_byte(b);
                    end
                end
                SC_BARE:   bare_byte(b);
                SC_QUOTED: quoted_byte(b);
                SC_ESC:
                begin
                    if (b == CH_QUOTE)
                    begin
                        mode = SC_ESCQ;
                    end
                    else if (b == CH_NUL)
                    begin
                        add(KIND_CHAR, CH_BSLASH);
                        quoted_byte(CH_NUL);
                    end
                    else
                    begin
                        add(KIND_CHAR, CH_BSLASH);
                        add(KIND_CHAR, b);
                        mode = SC_QUOTED;
                    end
                end
                SC_ESCQ:
                begin
                    add(KIND_CHAR, CH_BSLASH);
                    if (b == CH_CR || b == CH_LF)
                    begin
                        close_token();
                        idle_byte(b);
                    end
                    else
                    begin
                        add(KIND_CHAR, CH_QUOTE);
                        mode = SC_QUOTED;
                        quoted_byte(b);
                    end
                end
                SC_CSKIP:
                begin
                    if (b == CH_LF)
                    begin
                        next_line();
                        mode = SC_IDLE;
                    end
                    else if (b == CH_NUL)
                    begin
                        add(KIND_EOI, CH_NUL);
                        mode = SC_IDLE;
                    end
                end
                SC_CEMIT:
                begin
                    if (b == CH_LF)
                    begin
                        close_token();
                        next_line();
                    end
                    else if (b == CH_NUL)
                    begin
                        close_token();
                        add(KIND_EOI, CH_NUL);
                    end
                    else
                    begin
                        add(KIND_CHAR, b);
                    end
                end
                default:
                begin
                    mode = SC_IDLE;
                    idle_byte(b);
                end
            endcase
            if (run.size() > 0)
                run[run.size() - 1].last = 1'b1;
            foreach (run[i])
                due.insert(due.size(), run[i]);
        endfunction

        function void check_result(kind_t k, logic [7:0] ch, logic q, logic c,
                                   logic [23:0] line, logic last);
            token_res_t e;
            if (due.size() == 0)
            begin
                $error("result with nothing expected: kind %0d char %0d", k, ch);
                failures++;
                return;
            end
            e = due.pop_front();
            if (k !== e.kind)
            begin
                $error("kind: expected %0d, got %0d", e.kind, k);
                failures++;
            end
            if (ch !== e.ch)
            begin
                $error("token_char: expected %0d, got %0d", e.ch, ch);
                failures++;
            end
            if (q !== e.quoted)
            begin
                $error("in_quotes: expected %0d, got %0d", e.quoted, q);
                failures++;
            end
            if (c !== e.comment)
            begin
                $error("is_comment: expected %0d, got %0d", e.comment, c);
                failures++;
            end
            if (line !== e.line)
            begin
                $error("line_count: expected %0d, got %0d", e.line, line);
                failures++;
            end
            if (last !== e.last)
            begin
                $error("last_of_run: expected %0d, got %0d", e.last, last);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    bit   idle_on;
    int   stall_left;

    logic [7:0] script[$];
    token_scoreboard sb;

    mtt_in_if  in_ch();
    mtt_out_if out_ch();

    map_text_tokenizer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #500000;
        $display("[map_text_tokenizer] ERROR");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.text_byte <= b;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        sb.scan_byte(b);
    endtask

    task automatic send_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_emit(input logic v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        sb.emit_on = v;
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] word_char();
        return 8'($urandom_range(33, 255));
    endfunction

    function automatic void put_byte(input logic [7:0] c);
        script.insert(script.size(), c);
    endfunction

    // one well-formed token with random content, or a little noise
    function automatic void make_unit();
        int         pick;
        int         len;
        int         i;
        bit         closed;
        logic [7:0] c;
        pick   = $urandom_range(0, 99);
        len    = $urandom_range(0, 6);
        closed = 1'b0;
        if (pick < 30)
        begin
            put_byte(word_char());
            for (i = 0; i < len; i++)
                put_byte(word_char());
            put_byte(8'($urandom_range(1, 32)));
        end
        else if (pick < 38)
        begin
            put_byte(CH_SLASH);
            for (i = 0; i < len % 4; i++)
                put_byte(word_char());
            put_byte(8'($urandom_range(0, 32)));
        end
        else if (pick < 60)
        begin
            put_byte(CH_QUOTE);
            for (i = 0; i < len && !closed; i++)
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        put_byte(CH_BSLASH);
                        put_byte(8'($urandom_range(1, 255)));
                    end
                    1:
                    begin
                        put_byte(CH_BSLASH);
                        put_byte(CH_QUOTE);
                        if ($urandom_range(0, 1))
                        begin
                            put_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
                            closed = 1'b1;
                        end
                    end
                    2: put_byte(CH_LF);
                    default:
                    begin
                        c = 8'($urandom_range(1, 255));
                        if (c == CH_QUOTE || c == CH_BSLASH)
                            c = 8'h71;
                        put_byte(c);
                    end
                endcase
            end
            if (!closed)
            begin
                case ($urandom_range(0, 9))
                    0: put_byte(CH_NUL);
                    1:
                    begin
                        put_byte(CH_BSLASH);
                        put_byte(CH_NUL);
                    end
                    default: put_byte(CH_QUOTE);
                endcase
            end
        end
        else if (pick < 72)
        begin
            if ($urandom_range(0, 1))
            begin
                put_byte(CH_SEMI);
            end
            else
            begin
                put_byte(CH_SLASH);
                put_byte(CH_SLASH);
            end
            for (i = 0; i < len; i++)
            begin
                c = 8'($urandom_range(1, 255));
                if (c == CH_LF)
                    c = 8'h63;
                put_byte(c);
            end
            put_byte($urandom_range(0, 9) == 0 ? CH_NUL : CH_LF);
        end
        else if (pick < 80)
        begin
            put_byte(CH_NUL);
        end
        else if (pick < 90)
        begin
            for (i = 0; i <= len % 3; i++)
                put_byte($urandom_range(0, 2) == 0 ? CH_LF : 8'($urandom_range(1, 32)));
        end
        else
        begin
            for (i = 0; i <= len % 4; i++)
                put_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic random_phase(input int target);
        int sent;
        sent = 0;
        while (sent < target)
        begin
            script.delete();
            make_unit();
            foreach (script[i])
                send_byte(script[i]);
            sent += script.size();
        end
    endtask

    initial
    begin
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                sb.check_result(kind_t'(out_ch.kind), out_ch.token_char, out_ch.in_quotes,
                                out_ch.is_comment, out_ch.line_count, out_ch.last_of_run);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        sb      = new();
        idle_on = 1'b1;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.text_byte <= CH_NUL;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // comments skipped
        write_emit(1'b0);
        send_byte(CH_SPACE);
        send_str("!");
        send_byte(8'hFF);
        send_byte(8'h01);
        send_str("\"a\\\"\n;x\n\"\\");
        send_byte(CH_NUL);

        // comments emitted
        write_emit(1'b1);
        send_str("//z\n/");
        send_byte(CH_NUL);
        send_str("\"\\\"b\n\";");
        send_byte(CH_NUL);

        random_phase(60);
        write_emit(1'b0);
        random_phase(50);
        write_emit(1'b1);
        random_phase(40);
        write_emit(1'b0);
        idle_on = 1'b0;
        random_phase(40);

        wait_drained();
        if (sb.failures == 0)
            $display("[map_text_tokenizer] OK");
        else
            $display("[map_text_tokenizer] ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/mtt_pkg.sv
rtl/mtt_in_if.sv
rtl/mtt_out_if.sv
rtl/mtt_front.sv
rtl/mtt_fifo.sv
rtl/mtt_back.sv
rtl/map_text_tokenizer.sv
tb/sv/tb.sv
